// ----- src/dvsu_pkg.sv -----
// Shared types and constants for the 64-by-32 divider.
// No dependencies; used by every module in src but dvsu_checker.
`timescale 1ns / 1ps
package dvsu_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned DvdW  = 64;

  typedef struct packed {
    logic [WordW-1:0] rem;    // partial remainder, below the divisor
    logic [DvdW-1:0]  dvd;    // dividend magnitude, quotient bits shift in at the bottom
    logic [WordW-1:0] dvs;    // divisor magnitude
    logic             neg;    // signs of the two operands differ
    logic             a_neg;  // dividend negative
    logic             sgn;    // signed request
    logic             dz;     // divisor zero
  } dvsu_work_t;
endpackage

// ----- src/dvsu_prep.sv -----
// Operand preparation: sign split and magnitudes.
// Depends on dvsu_pkg.
`timescale 1ns / 1ps
module dvsu_prep (
  input  logic [31:0]        dividend_high_i,
  input  logic [31:0]        dividend_low_i,
  input  logic [31:0]        divisor_i,
  input  logic               is_signed_i,
  output dvsu_pkg::dvsu_work_t work_o
);
  logic [63:0] dvd;
  logic        a_neg, b_neg;

  always_comb begin
    dvd   = {dividend_high_i, dividend_low_i};
    a_neg = is_signed_i & dvd[63];
    b_neg = is_signed_i & divisor_i[31];
    work_o.rem   = '0;
    work_o.dvd   = a_neg ? (~dvd + 64'd1) : dvd;
    work_o.dvs   = b_neg ? (~divisor_i + 32'd1) : divisor_i;
    work_o.neg   = a_neg ^ b_neg;
    work_o.a_neg = a_neg;
    work_o.sgn   = is_signed_i;
    work_o.dz    = (divisor_i == '0);
  end
endmodule

// ----- src/dvsu_stage.sv -----
// One pipeline stage of restoring division: STEPS quotient bits.
// Depends on dvsu_pkg.
`timescale 1ns / 1ps
module dvsu_stage #(
  parameter int unsigned STEPS = 4
) (
  input  dvsu_pkg::dvsu_work_t work_i,
  output dvsu_pkg::dvsu_work_t work_o
);
  logic [32:0] trial;
  logic [32:0] rem;

  always_comb begin
    work_o = work_i;
    for (int unsigned s = 0; s < STEPS; s++) begin
      rem   = {work_o.rem, work_o.dvd[63]};
      trial = rem - {1'b0, work_o.dvs};
      work_o.dvd = {work_o.dvd[62:0], ~trial[32]};
      work_o.rem = trial[32] ? rem[31:0] : trial[31:0];
    end
  end
endmodule

// ----- src/dvsu_post.sv -----
// Result formatting: sign, saturation and flags.
// Depends on dvsu_pkg.
`timescale 1ns / 1ps
module dvsu_post (
  input  dvsu_pkg::dvsu_work_t work_i,
  output logic [31:0]          quotient_o,
  output logic                 negative_flag_o,
  output logic                 zero_flag_o,
  output logic                 overflow_flag_o
);
  logic        hi_nz;
  logic [31:0] q;
  logic        ovf;

  always_comb begin
    hi_nz = (work_i.dvd[63:32] != '0);
    q     = work_i.dvd[31:0];
    ovf   = 1'b0;
    if (work_i.dz) begin
      ovf = 1'b1;
      q   = !work_i.sgn ? 32'hFFFF_FFFF : (work_i.a_neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else if (!work_i.sgn) begin
      if (hi_nz) begin
        ovf = 1'b1;
        q   = 32'hFFFF_FFFF;
      end
    end else if (work_i.neg) begin
      if (hi_nz || (q[31] && q[30:0] != '0)) begin
        ovf = 1'b1;
        q   = 32'h8000_0000;
      end else begin
        q = ~q + 32'd1;
      end
    end else if (hi_nz || q[31]) begin
      ovf = 1'b1;
      q   = 32'h7FFF_FFFF;
    end
    quotient_o      = q;
    negative_flag_o = q[31];
    zero_flag_o     = (q == '0) && !ovf;
    overflow_flag_o = ovf;
  end
endmodule

// ----- src/divide_64_by_32_signed_unsigned.sv -----
// Pipelined 64-by-32 signed/unsigned divider: top level.
// Depends on dvsu_pkg, dvsu_prep, dvsu_stage and dvsu_post.
`timescale 1ns / 1ps
// One transaction may enter every cycle while in_stall_o is low. Operand
// magnitudes are formed in the accepting cycle and captured at the accepting
// edge. Next come the stages of restoring division, each settling 64/NSTAGES
// quotient bits with a 33-bit subtract per bit. Then the result register
// takes the sign fix-up, saturation and flags. A stage loads when it is empty
// or the stage after it moves on. A stall at the output holds every full stage
// behind it and loses nothing; bubbles are squeezed out. Quotient bits above
// 31 only decide overflow.
module divide_64_by_32_signed_unsigned #(
  parameter int unsigned NSTAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] dividend_high_i,
  input  logic [31:0] dividend_low_i,
  input  logic [31:0] divisor_i,
  input  logic        is_signed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] quotient_o,
  output logic        negative_flag_o,
  output logic        zero_flag_o,
  output logic        overflow_flag_o
);
  localparam int unsigned Steps = 64 / NSTAGES;

  dvsu_pkg::dvsu_work_t pipe_q [NSTAGES+1];
  dvsu_pkg::dvsu_work_t pipe_d [NSTAGES+1];
  logic [NSTAGES:0]     vld_q;
  logic [NSTAGES:0]     vld_d;
  logic                 adv  [NSTAGES+2];
  logic [31:0] q_d, q_q;
  logic        n_d, n_q, z_d, z_q, v_d, v_q;
  logic        out_vld_q;

  dvsu_prep u_prep (
    .dividend_high_i, .dividend_low_i, .divisor_i, .is_signed_i,
    .work_o (pipe_d[0])
  );

  for (genvar g = 0; g < NSTAGES; g++) begin : g_stage
    dvsu_stage #(.STEPS(Steps)) u_stage (.work_i(pipe_q[g]), .work_o(pipe_d[g+1]));
  end

  dvsu_post u_post (
    .work_i (pipe_q[NSTAGES]),
    .quotient_o (q_d), .negative_flag_o (n_d), .zero_flag_o (z_d), .overflow_flag_o (v_d)
  );

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    adv[NSTAGES+1] = !out_vld_q || !out_stall_i;
    for (int i = NSTAGES; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
    vld_d[0] = in_valid_i;
    for (int i = 1; i <= NSTAGES; i++) begin
      vld_d[i] = vld_q[i-1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      for (int i = 0; i <= NSTAGES; i++) begin
        if (adv[i]) vld_q[i] <= vld_d[i];
      end
      if (adv[NSTAGES+1]) out_vld_q <= vld_q[NSTAGES];
    end
  end

  // Payload: hold on stall, no reset needed.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= NSTAGES; i++) begin
      if (adv[i] && vld_d[i]) pipe_q[i] <= pipe_d[i];
    end
    if (adv[NSTAGES+1] && vld_q[NSTAGES]) begin
      q_q <= q_d;
      n_q <= n_d;
      z_q <= z_d;
      v_q <= v_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign quotient_o      = q_q;
  assign negative_flag_o = n_q;
  assign zero_flag_o     = z_q;
  assign overflow_flag_o = v_q;
endmodule

// ----- src/dvsu_checker.sv -----
// Port-level checker for the divider, bound to the top level.
// Depends on divide_64_by_32_signed_unsigned only through its ports.
`timescale 1ns / 1ps
module dvsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] quotient_o,
  input logic        negative_flag_o,
  input logic        zero_flag_o,
  input logic        overflow_flag_o
);
  a_neg_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> negative_flag_o == quotient_o[31]) else $error("N flag mismatch");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_flag_o |-> quotient_o == '0 && !overflow_flag_o)
    else $error("Z flag wrong");
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_flag_o |-> quotient_o == 32'hFFFF_FFFF
      || quotient_o == 32'h7FFF_FFFF || quotient_o == 32'h8000_0000)
    else $error("overflow without saturation");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(quotient_o))
    else $error("stalled result changed");
endmodule

bind divide_64_by_32_signed_unsigned dvsu_checker u_dvsu_checker (.*);

// ----- sim/divide_64_by_32_signed_unsigned_checker.sv -----
// Checker for the 64-by-32 divider: watches both channels, predicts each
// quotient and its flags, and compares. Depends only on the block's port list.
`timescale 1ns / 1ps
module divide_64_by_32_signed_unsigned_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] dividend_high_i,
  input  logic [31:0] dividend_low_i,
  input  logic [31:0] divisor_i,
  input  logic        is_signed_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] quotient_i,
  input  logic        negative_flag_i,
  input  logic        zero_flag_i,
  input  logic        overflow_flag_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  typedef struct packed {
    logic [31:0] quot;
    logic        n;
    logic        z;
    logic        v;
  } div_result_t;

  div_result_t pending_results[$];

  function automatic div_result_t pack_result(logic [31:0] q, logic v);
    div_result_t r;
    r.quot = q;
    r.n    = q[31];
    r.z    = (q == 32'd0) && !v;
    r.v    = v;
    return r;
  endfunction

  function automatic div_result_t predict_quotient(logic [31:0] hi, logic [31:0] lo,
                                                   logic [31:0] dv, logic sgn);
    logic [63:0] dvd;
    logic [63:0] amag;
    logic [63:0] qmag;
    logic [31:0] bmag;
    logic        a_neg;
    logic        b_neg;
    dvd = {hi, lo};
    if (!sgn) begin
      if (dv == 32'd0) return pack_result(32'hFFFF_FFFF, 1'b1);
      qmag = dvd / {32'd0, dv};
      if (qmag > 64'hFFFF_FFFF) return pack_result(32'hFFFF_FFFF, 1'b1);
      return pack_result(qmag[31:0], 1'b0);
    end
    a_neg = dvd[63];
    b_neg = dv[31];
    amag  = a_neg ? (~dvd + 64'd1) : dvd;
    bmag  = b_neg ? (~dv + 32'd1) : dv;
    if (bmag == 32'd0) return pack_result(a_neg ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b1);
    qmag = amag / {32'd0, bmag};
    if (a_neg != b_neg) begin
      if (qmag > 64'h8000_0000) return pack_result(32'h8000_0000, 1'b1);
      qmag = ~qmag + 64'd1;
      return pack_result(qmag[31:0], 1'b0);
    end
    if (qmag > 64'h7FFF_FFFF) return pack_result(32'h7FFF_FFFF, 1'b1);
    return pack_result(qmag[31:0], 1'b0);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
  end

  assign pending_o = pending_results.size();

  always @(posedge clk_i) begin
    div_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        pending_results.push_back(predict_quotient(dividend_high_i, dividend_low_i,
                                                   divisor_i, is_signed_i));
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (quotient_i !== want.quot)
            report_mismatch($sformatf("quotient %h, want %h", quotient_i, want.quot));
          if (negative_flag_i !== want.n)
            report_mismatch($sformatf("N %b, want %b", negative_flag_i, want.n));
          if (zero_flag_i !== want.z)
            report_mismatch($sformatf("Z %b, want %b", zero_flag_i, want.z));
          if (overflow_flag_i !== want.v)
            report_mismatch($sformatf("V %b, want %b", overflow_flag_i, want.v));
        end
      end
    end
  end
endmodule

// ----- sim/divide_64_by_32_signed_unsigned_tb.sv -----
// Testbench top for the 64-by-32 divider: clock, reset, stimulus and verdict.
// Depends on divide_64_by_32_signed_unsigned and its checker module.
`timescale 1ns / 1ps
module divide_64_by_32_signed_unsigned_tb;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] dvd_hi;
  logic [31:0] dvd_lo;
  logic [31:0] dvs;
  logic        sgn;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] quot;
  logic        n_flag;
  logic        z_flag;
  logic        v_flag;
  int          fail_count;
  int          pending;
  int          checked;

  // Idle rates in percent; the stimulus changes them phase by phase
  int send_idle_pct;
  int recv_idle_pct;

  divide_64_by_32_signed_unsigned i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .dividend_high_i (dvd_hi),
    .dividend_low_i  (dvd_lo),
    .divisor_i       (dvs),
    .is_signed_i     (sgn),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .quotient_o      (quot),
    .negative_flag_o (n_flag),
    .zero_flag_o     (z_flag),
    .overflow_flag_o (v_flag)
  );

  divide_64_by_32_signed_unsigned_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .dividend_high_i (dvd_hi),
    .dividend_low_i  (dvd_lo),
    .divisor_i       (dvs),
    .is_signed_i     (sgn),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .quotient_i      (quot),
    .negative_flag_i (n_flag),
    .zero_flag_i     (z_flag),
    .overflow_flag_i (v_flag),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: redraw the stall at every falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one transaction: idle first at random, then hold valid until taken.
  // Valid stays high straight into the next call, so it is never dropped and
  // raised in one step.
  task automatic send_division(logic [31:0] hi, logic [31:0] lo, logic [31:0] dv,
                               logic s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    dvd_hi   <= hi;
    dvd_lo   <= lo;
    dvs      <= dv;
    sgn      <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Pick an operand word biased towards edges and small magnitudes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(15);
      5: return -$urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Build a request whose quotient usually fits, so most results are not
  // saturated: the upper dividend word is kept below an unsigned divisor
  task automatic send_random();
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] dv;
    logic        s;
    s  = $urandom_range(1);
    dv = pick_word();
    lo = $urandom;
    if ($urandom_range(3) == 0) begin
      hi = pick_word();
    end else if (!s) begin
      hi = (dv == 0) ? 32'd0 : $urandom % dv;
    end else begin
      // signed: small magnitude high part, sign-extended
      hi = {32{lo[31]}};
      if ($urandom_range(1)) begin
        lo = $urandom_range(1) ? -($urandom % 32'h4000_0000) : ($urandom % 32'h4000_0000);
        hi = {32{lo[31]}};
      end
    end
    send_division(hi, lo, dv, s);
  endtask

  initial begin
    in_valid      = 1'b0;
    dvd_hi        = '0;
    dvd_lo        = '0;
    dvs           = '0;
    sgn           = 1'b0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, zero divisor, saturation and the negative-zero case
    send_division(32'h0, 32'h0, 32'h1, 1'b0);
    send_division(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_division(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_division(32'h1, 32'h0, 32'h1, 1'b0);
    send_division(32'h1234, 32'h5678, 32'h0, 1'b0);
    send_division(32'h0, 32'h5, 32'h0, 1'b1);
    send_division(32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'h0, 1'b1);
    send_division(32'hFFFF_FFFF, 32'h8000_0000, 32'h1, 1'b1);
    send_division(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_division(32'h0, 32'h8000_0000, 32'h1, 1'b1);
    send_division(32'h0, 32'h7FFF_FFFF, 32'h1, 1'b1);
    send_division(32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_division(32'h0, 32'h8000_0001, 32'hFFFF_FFFF, 1'b1);
    send_division(32'h8000_0000, 32'h0, 32'h1, 1'b1);
    send_division(32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b1);
    send_division(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    send_division(32'h0, 32'h3, 32'hFFFF_FFF9, 1'b1);
    send_division(32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'h7, 1'b1);
    send_division(32'hFFFF_FFFF, 32'hFFFF_FFF9, 32'hFFFF_FFFD, 1'b1);
    send_division(32'h0, 32'h64, 32'hFFFF_FFF6, 1'b1);

    // Random phases: sender idles lightly, then receiver lightly, then neither
    send_idle_pct = 12;
    recv_idle_pct = 79;
    repeat (630) send_random();

    // Hold off until the pipe has drained
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    send_idle_pct = 79;
    recv_idle_pct = 12;
    repeat (630) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (640) send_random();
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("Covered directed edge cases and %0d checked results over three idle mixes.",
             checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far above the slowest correct run
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end
endmodule
